### sv/csho_pkg.sv
// shared types and constants for the convex slab hull overlap unit
// no dependencies; imported by every module of the block
`default_nettype none

package csho_pkg;

  // hull size and derived widths
  localparam int MAX_FACES = 32;
  localparam int FI_W      = $clog2(MAX_FACES);
  localparam int NW        = $clog2(MAX_FACES + 1);
  localparam int CNT_W     = $clog2(MAX_FACES + 3);
  localparam int PROD_W    = 51;
  localparam int ACC_W     = PROD_W + $clog2(MAX_FACES) + 1;
  localparam int DIV_W     = ACC_W - 14;
  localparam int DCW       = $clog2(DIV_W + 1);

  // register file
  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_ACTIVE = 1'd0;
  localparam logic [ADDR_W-3:0] REG_RADIUS = 1'd1;

  // item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  typedef enum logic [1:0] {
    REL_FRONT = 2'd0,
    REL_BACK  = 2'd1,
    REL_INTER = 2'd2
  } rel_t;

  typedef struct packed {
    logic               op;
    logic [4:0]         face_index;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] slab_low;
    logic signed [31:0] slab_high;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [1:0]         relation;
    logic signed [31:0] inter_x;
    logic signed [31:0] inter_y;
    logic signed [31:0] inter_z;
  } out_t;

  // one face slab
  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } face_t;

  // running projection range of one face
  typedef struct packed {
    logic signed [31:0] mn;
    logic signed [31:0] mx;
  } rng_t;

endpackage

`default_nettype wire

### sv/csho_cell.sv
// one cell of the face ring: holds a slab and its projection range
// depends on csho_pkg
`default_nettype none

module csho_cell (
  input  wire logic           clk,
  input  wire logic           face_shift,
  input  wire logic           face_load,
  input  wire csho_pkg::face_t face_ld,
  input  wire csho_pkg::face_t face_in,
  output csho_pkg::face_t     face_out,
  input  wire logic           rng_shift,
  input  wire csho_pkg::rng_t rng_in,
  output csho_pkg::rng_t      rng_out
);
  import csho_pkg::*;

  face_t face;
  rng_t  rng;

  // slab store, loaded directly or passed along the ring
  always_ff @(posedge clk) begin
    if (face_load) begin
      face <= face_ld;
    end else if (face_shift) begin
      face <= face_in;
    end
  end

  // range store moves on its own schedule
  always_ff @(posedge clk) begin
    if (rng_shift) begin
      rng <= rng_in;
    end
  end

  assign face_out = face;
  assign rng_out  = rng;

endmodule

`default_nettype wire

### sv/csho_proj.sv
// two-stage projection of a point onto a face normal, floor and saturate
// depends on csho_pkg
`default_nettype none

module csho_proj (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_v,
  input  wire logic signed [15:0] nx,
  input  wire logic signed [15:0] ny,
  input  wire logic signed [15:0] nz,
  input  wire logic signed [31:0] px,
  input  wire logic signed [31:0] py,
  input  wire logic signed [31:0] pz,
  output logic                    out_v,
  output logic signed [31:0]      d
);
  import csho_pkg::*;

  logic               s1_v;
  logic signed [47:0] mx_q, my_q, mz_q;
  logic signed [49:0] sum;
  logic signed [35:0] sh;

  // stage 1: three products
  always_ff @(posedge clk) begin
    mx_q <= nx * px;
    my_q <= ny * py;
    mz_q <= nz * pz;
  end

  // stage 2: sum, floor shift, saturate
  assign sum = 50'(mx_q) + 50'(my_q) + 50'(mz_q);
  assign sh  = 36'(sum >>> 14);

  always_ff @(posedge clk) begin
    if (sh > 36'sh0_7FFF_FFFF) begin
      d <= 32'sh7FFF_FFFF;
    end else if (sh < -36'sh0_8000_0000) begin
      d <= 32'sh8000_0000;
    end else begin
      d <= sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      s1_v  <= in_v;
      out_v <= s1_v;
    end
  end

endmodule

`default_nettype wire

### sv/csho_div.sv
// restoring divider, one quotient bit a cycle
// depends on csho_pkg
`default_nettype none

module csho_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [csho_pkg::DIV_W-1:0] dividend,
  input  wire logic [csho_pkg::NW-1:0]    divisor,
  output logic                  done,
  output logic [csho_pkg::DIV_W-1:0]      quot
);
  import csho_pkg::*;

  logic [DIV_W-1:0] qr;
  logic [NW-1:0]    rm;
  logic [NW:0]      trial, diff;
  logic [DCW-1:0]   cnt;
  logic             run, ge;

  // trial subtract of the next bit
  assign trial = {rm, qr[DIV_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (start) begin
      qr <= dividend;
      rm <= '0;
    end else if (run) begin
      qr <= {qr[DIV_W-2:0], ge};
      rm <= ge ? diff[NW-1:0] : trial[NW-1:0];
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= DCW'(DIV_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = qr;

endmodule

`default_nettype wire

### sv/convex_slab_hull_overlap_unit.sv
// top level: face ring, projection pass, slab test and mean overlap point
// depends on csho_pkg, csho_cell, csho_proj, csho_div
`default_nettype none

// A slab load (op 0) goes straight into its cell of the face ring. For a query
// point (op 1) the face ring turns once through the shared two-stage projection
// unit, one face a cycle. The point marked last then adds a test pass over the
// same ring and, unless separated, a division in three bit-serial dividers for
// the overlap point; a result waits in the output register while the next item
// is taken.
module convex_slab_hull_overlap_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire csho_pkg::in_t              in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output csho_pkg::out_t                  out_data,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [csho_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import csho_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PROJ, S_TEST, S_DIV, S_EMIT} state_t;

  state_t state;
  logic [5:0]  active_faces;
  logic [30:0] radius;
  logic [ADDR_W-3:0] reg_idx;
  logic        in_acc;
  logic        first_point, last_q;
  logic signed [31:0] pt_x, pt_y, pt_z;
  logic [CNT_W-1:0] fcnt, rcnt, tcnt;
  logic [NW-1:0] n_eff;

  face_t face_o [MAX_FACES];
  rng_t  rng_o  [MAX_FACES];
  face_t face_ld;
  rng_t  rng_upd, rng_tail;
  logic  face_shift, rng_shift;

  logic        p_in_v, p_out_v;
  logic signed [31:0] p_d;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      active_faces <= 6'd1;
      radius       <= '0;
    end else if (psel && penable && pwrite) begin
      if (reg_idx == REG_ACTIVE) begin
        active_faces <= pwdata[5:0];
      end else if (reg_idx == REG_RADIUS) begin
        radius <= pwdata[30:0];
      end
    end
  end
  always_comb begin
    if (reg_idx == REG_ACTIVE) begin
      prdata = {26'd0, active_faces};
    end else if (reg_idx == REG_RADIUS) begin
      prdata = {1'b0, radius};
    end else begin
      prdata = '0;
    end
  end

  // clamped face count
  always_comb begin
    if (active_faces == 6'd0) begin
      n_eff = NW'(1);
    end else if (32'(active_faces) > 32'(MAX_FACES)) begin
      n_eff = NW'(MAX_FACES);
    end else begin
      n_eff = NW'(active_faces);
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // face ring
  assign face_ld = '{nx: in_data.normal_x, ny: in_data.normal_y, nz: in_data.normal_z,
                     lo: in_data.slab_low, hi: in_data.slab_high};
  assign face_shift = (state == S_PROJ && 32'(fcnt) < 32'(MAX_FACES)) ||
                      (state == S_TEST && 32'(tcnt) < 32'(MAX_FACES));
  assign rng_shift  = (state == S_PROJ && p_out_v) ||
                      (state == S_TEST && 32'(tcnt) < 32'(MAX_FACES));

  // range update from the projection result
  always_comb begin
    rng_upd.mn = (first_point || p_d < rng_o[0].mn) ? p_d : rng_o[0].mn;
    rng_upd.mx = (first_point || p_d > rng_o[0].mx) ? p_d : rng_o[0].mx;
    rng_tail   = (state == S_TEST) ? rng_o[0] : rng_upd;
  end

  for (genvar k = 0; k < MAX_FACES; k++) begin : g_cell
    face_t f_in;
    rng_t  r_in;
    logic  ld;
    if (k == MAX_FACES - 1) begin : g_tail
      assign f_in = face_o[0];
      assign r_in = rng_tail;
    end else begin : g_mid
      assign f_in = face_o[k+1];
      assign r_in = rng_o[k+1];
    end
    assign ld = in_acc && in_data.op == OP_LOAD &&
                32'(in_data.face_index) == 32'(k);
    csho_cell u_cell (
      .clk        (clk),
      .face_shift (face_shift),
      .face_load  (ld),
      .face_ld    (face_ld),
      .face_in    (f_in),
      .face_out   (face_o[k]),
      .rng_shift  (rng_shift),
      .rng_in     (r_in),
      .rng_out    (rng_o[k])
    );
  end

  // shared projection unit
  assign p_in_v = (state == S_PROJ) && 32'(fcnt) < 32'(MAX_FACES);
  csho_proj u_proj (
    .clk   (clk),
    .rst   (rst),
    .in_v  (p_in_v),
    .nx    (face_o[0].nx),
    .ny    (face_o[0].ny),
    .nz    (face_o[0].nz),
    .px    (pt_x),
    .py    (pt_y),
    .pz    (pt_z),
    .out_v (p_out_v),
    .d     (p_d)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pt_x <= in_data.point_x;
      pt_y <= in_data.point_y;
      pt_z <= in_data.point_z;
    end
  end

  // slab test stage a: widen and compare
  logic signed [33:0] w_lo, w_hi, s_l, s_h;
  logic signed [34:0] w_s;
  logic a_v, a_act, a_sep, a_enc;
  logic signed [34:0] a_s;
  logic signed [15:0] a_nx, a_ny, a_nz;
  always_comb begin
    w_lo = 34'(rng_o[0].mn) - 34'(signed'({1'b0, radius}));
    w_hi = 34'(rng_o[0].mx) + 34'(signed'({1'b0, radius}));
    s_l  = 34'(face_o[0].lo);
    s_h  = 34'(face_o[0].hi);
    w_s  = 35'((w_lo > s_l) ? w_lo : s_l) + 35'((w_hi < s_h) ? w_hi : s_h);
  end
  always_ff @(posedge clk) begin
    a_act <= 32'(tcnt) < 32'(n_eff);
    a_sep <= (w_hi < s_l) || (w_lo > s_h);
    a_enc <= (s_l < w_lo) && (w_hi <= s_h);
    a_s   <= w_s;
    a_nx  <= face_o[0].nx;
    a_ny  <= face_o[0].ny;
    a_nz  <= face_o[0].nz;
  end

  // stage b: weight by the normal
  logic b_v, b_act, b_sep, b_enc;
  logic signed [PROD_W-1:0] b_x, b_y, b_z;
  always_ff @(posedge clk) begin
    b_act <= a_act;
    b_sep <= a_sep;
    b_enc <= a_enc;
    b_x   <= PROD_W'(a_nx * a_s);
    b_y   <= PROD_W'(a_ny * a_s);
    b_z   <= PROD_W'(a_nz * a_s);
  end

  // stage c: accumulate until a separated slab
  logic test_clr;
  logic front, back;
  logic signed [ACC_W-1:0] acc_x, acc_y, acc_z;
  always_ff @(posedge clk) begin
    if (test_clr) begin
      front <= 1'b0;
      back  <= 1'b1;
      acc_x <= '0;
      acc_y <= '0;
      acc_z <= '0;
    end else if (b_v && b_act && !front) begin
      if (b_sep) begin
        front <= 1'b1;
      end else begin
        back  <= back & b_enc;
        acc_x <= acc_x + ACC_W'(b_x);
        acc_y <= acc_y + ACC_W'(b_y);
        acc_z <= acc_z + ACC_W'(b_z);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else begin
      a_v <= (state == S_TEST) && 32'(tcnt) < 32'(MAX_FACES);
      b_v <= a_v;
    end
  end

  // magnitudes for the dividers
  logic [ACC_W-1:0] mag_x, mag_y, mag_z;
  assign mag_x = acc_x[ACC_W-1] ? ACC_W'(-acc_x) : ACC_W'(acc_x);
  assign mag_y = acc_y[ACC_W-1] ? ACC_W'(-acc_y) : ACC_W'(acc_y);
  assign mag_z = acc_z[ACC_W-1] ? ACC_W'(-acc_z) : ACC_W'(acc_z);

  logic test_end, div_start, dx_done, dy_done, dz_done;
  logic [DIV_W-1:0] q_x, q_y, q_z;
  assign test_end  = (state == S_TEST) && 32'(tcnt) == 32'(MAX_FACES + 2);
  assign div_start = test_end && !front;
  assign test_clr  = (state == S_PROJ) && p_out_v &&
                     32'(rcnt) == 32'(MAX_FACES - 1) && last_q;

  csho_div u_div_x (.clk(clk), .rst(rst), .start(div_start),
    .dividend(mag_x[ACC_W-1:14]), .divisor(n_eff), .done(dx_done), .quot(q_x));
  csho_div u_div_y (.clk(clk), .rst(rst), .start(div_start),
    .dividend(mag_y[ACC_W-1:14]), .divisor(n_eff), .done(dy_done), .quot(q_y));
  csho_div u_div_z (.clk(clk), .rst(rst), .start(div_start),
    .dividend(mag_z[ACC_W-1:14]), .divisor(n_eff), .done(dz_done), .quot(q_z));

  // signed saturation of a quotient
  function automatic logic [31:0] sat_q(input logic neg, input logic [DIV_W-1:0] q);
    logic [31:0] r;
    if (!neg) begin
      r = (q > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      r = (q > DIV_W'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-q[31:0]);
    end
    return r;
  endfunction

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      first_point <= 1'b1;
      last_q      <= 1'b0;
      fcnt        <= '0;
      rcnt        <= '0;
      tcnt        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && in_data.op == OP_POINT) begin
            last_q <= in_data.last;
            fcnt   <= '0;
            rcnt   <= '0;
            state  <= S_PROJ;
          end
        end
        S_PROJ: begin
          if (32'(fcnt) < 32'(MAX_FACES)) begin
            fcnt <= fcnt + 1'b1;
          end
          if (p_out_v) begin
            rcnt <= rcnt + 1'b1;
            if (32'(rcnt) == 32'(MAX_FACES - 1)) begin
              first_point <= last_q;
              tcnt        <= '0;
              state       <= last_q ? S_TEST : S_IDLE;
            end
          end
        end
        S_TEST: begin
          tcnt <= tcnt + 1'b1;
          if (test_end) begin
            state <= front ? S_EMIT : S_DIV;
          end
        end
        S_DIV: begin
          if (dx_done && dy_done && dz_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            if (front) begin
              out_data <= '{relation: REL_FRONT, inter_x: '0, inter_y: '0, inter_z: '0};
            end else begin
              out_data.relation <= back ? REL_BACK : REL_INTER;
              out_data.inter_x  <= sat_q(acc_x[ACC_W-1], q_x);
              out_data.inter_y  <= sat_q(acc_y[ACC_W-1], q_y);
              out_data.inter_z  <= sat_q(acc_z[ACC_W-1], q_z);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/csho_checker.sv
// port-level checks for the convex slab hull overlap unit, bound to the top
// depends on csho_pkg and convex_slab_hull_overlap_unit
`default_nettype none

module csho_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire csho_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire csho_pkg::out_t out_data,
  input wire logic           pready
);
  import csho_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // a separated hull reports a zero point
  a_front_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.relation == REL_FRONT |->
      out_data.inter_x == 0 && out_data.inter_y == 0 && out_data.inter_z == 0)
    else $error("front result with nonzero point");

  // relation code in range
  a_rel_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.relation != 2'd3)
    else $error("bad relation code");

  // a point beat starts a projection pass
  a_point_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.op == OP_POINT |=> !in_ready)
    else $error("input taken during projection pass");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind convex_slab_hull_overlap_unit csho_checker u_csho_checker (.*);

`default_nettype wire

### dv/tb_top.sv
// self-checking testbench for convex_slab_hull_overlap_unit
// depends on csho_pkg and the rtl of the unit; no files or arguments read
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import csho_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  convex_slab_hull_overlap_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // hull copy, running ranges and register shadow
  logic signed [15:0] hull_nx [MAX_FACES];
  logic signed [15:0] hull_ny [MAX_FACES];
  logic signed [15:0] hull_nz [MAX_FACES];
  logic signed [31:0] hull_lo [MAX_FACES];
  logic signed [31:0] hull_hi [MAX_FACES];
  logic signed [31:0] span_min [MAX_FACES];
  logic signed [31:0] span_max [MAX_FACES];
  bit       new_query = 1'b1;
  bit [5:0] face_count = 6'd1;
  bit [30:0] widen = '0;

  out_t overlap_q [$];
  int   errors = 0;
  int   beats_sent = 0;
  bit   sender_busy = 1'b1;

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // advances the hull model by one beat; returns 1 when a result is due
  function automatic bit hull_predict(in_t b, output out_t res);
    longint d, lo, hi, fl, fh, s, ax, ay, az, dv;
    int n;
    bit back, sep;
    logic signed [31:0] p;
    res = '0;
    if (b.op == OP_LOAD) begin
      hull_nx[b.face_index] = b.normal_x;
      hull_ny[b.face_index] = b.normal_y;
      hull_nz[b.face_index] = b.normal_z;
      hull_lo[b.face_index] = b.slab_low;
      hull_hi[b.face_index] = b.slab_high;
      return 1'b0;
    end
    for (int i = 0; i < MAX_FACES; i++) begin
      d = longint'(hull_nx[i]) * longint'(b.point_x) + longint'(hull_ny[i]) * longint'(b.point_y)
          + longint'(hull_nz[i]) * longint'(b.point_z);
      p = clip32(d >>> 14);
      if (new_query || p < span_min[i]) span_min[i] = p;
      if (new_query || p > span_max[i]) span_max[i] = p;
    end
    new_query = 1'b0;
    if (!b.last) return 1'b0;
    new_query = 1'b1;
    n = (face_count == 0) ? 1 : (face_count > MAX_FACES) ? MAX_FACES : face_count;
    ax = 0; ay = 0; az = 0; back = 1'b1; sep = 1'b0;
    for (int i = 0; i < n; i++) begin
      lo = longint'(span_min[i]) - longint'(widen);
      hi = longint'(span_max[i]) + longint'(widen);
      fl = hull_lo[i];
      fh = hull_hi[i];
      if (hi < fl || lo > fh) begin
        sep = 1'b1;
        break;
      end
      if (!(fl < lo && hi <= fh)) back = 1'b0;
      s = ((lo > fl) ? lo : fl) + ((hi < fh) ? hi : fh);
      ax += longint'(hull_nx[i]) * s;
      ay += longint'(hull_ny[i]) * s;
      az += longint'(hull_nz[i]) * s;
    end
    if (sep) begin
      res.relation = REL_FRONT;
      return 1'b1;
    end
    dv = longint'(n) * 16384;
    res.relation = back ? REL_BACK : REL_INTER;
    res.inter_x = clip32(ax / dv);
    res.inter_y = clip32(ay / dv);
    res.inter_z = clip32(az / dv);
    return 1'b1;
  endfunction

  // one beat on the input channel, with random idle cycles ahead of it, none for beats 250 to 349
  task automatic send_beat(in_t b, bit typed, out_t want);
    out_t res;
    bit due;
    int gap;
    gap = 0;
    if (!(beats_sent >= 250 && beats_sent < 350))
      while ($urandom_range(99) < 35 && gap < 8) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    due = hull_predict(b, res);
    if (due) overlap_q.push_back(typed ? want : res);
  endtask

  // register write through the apb port, only while the unit is idle
  task automatic reg_write(logic [ADDR_W-3:0] idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_ACTIVE) face_count = val[5:0];
    else widen = val[30:0];
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (overlap_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic in_t rand_beat();
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_t)-1:0];
  endfunction

  // slab around the origin with a modest normal, or a fully random one
  function automatic in_t face_beat(int fi, bit wild);
    in_t b;
    b = rand_beat();
    b.op = OP_LOAD;
    b.face_index = 5'(fi);
    if (!wild) begin
      b.normal_x  = 16'($urandom_range(32768) - 16384);
      b.normal_y  = 16'($urandom_range(32768) - 16384);
      b.normal_z  = 16'($urandom_range(32768) - 16384);
      b.slab_low  = -$signed($urandom_range(20 << 16, 1 << 16));
      b.slab_high = $urandom_range(20 << 16, 1 << 16);
    end
    return b;
  endfunction

  function automatic in_t point_beat(bit is_last, bit wild);
    in_t b;
    b = rand_beat();
    b.op = OP_POINT;
    b.last = is_last;
    if (!wild) begin
      b.point_x = $urandom_range(4 << 16) - (2 << 16);
      b.point_y = $urandom_range(4 << 16) - (2 << 16);
      b.point_z = $urandom_range(4 << 16) - (2 << 16);
    end
    return b;
  endfunction

  // directed table
  typedef struct {
    in_t  b;
    bit   typed;
    out_t want;
  } row_t;

  function automatic in_t mk(bit op, int fi, int nx, int ny, int nz, int lo, int hi,
                             int px, int py, int pz, bit lst);
    in_t b;
    b.op = op; b.face_index = 5'(fi);
    b.normal_x = 16'(nx); b.normal_y = 16'(ny); b.normal_z = 16'(nz);
    b.slab_low = lo; b.slab_high = hi;
    b.point_x = px; b.point_y = py; b.point_z = pz; b.last = lst;
    return b;
  endfunction

  function automatic out_t ov(rel_t r, int x, int y, int z);
    out_t o;
    o.relation = r; o.inter_x = x; o.inter_y = y; o.inter_z = z;
    return o;
  endfunction

  // result side: random stalls, one long hold-off, one stretch always ready
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 3000 && cyc < 3600) out_ready <= 1'b0;
      else if (cyc >= 6000 && cyc < 8000) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 35);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (overlap_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = overlap_q.pop_front();
        if (out_data.relation !== want.relation) begin
          $display("%0t: relation expected %0d actual %0d", $time, want.relation,
                   out_data.relation);
          errors++;
        end
        if (out_data.inter_x !== want.inter_x) begin
          $display("%0t: inter_x expected %h actual %h", $time, want.inter_x,
                   out_data.inter_x);
          errors++;
        end
        if (out_data.inter_y !== want.inter_y) begin
          $display("%0t: inter_y expected %h actual %h", $time, want.inter_y,
                   out_data.inter_y);
          errors++;
        end
        if (out_data.inter_z !== want.inter_z) begin
          $display("%0t: inter_z expected %h actual %h", $time, want.inter_z,
                   out_data.inter_z);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    row_t  rows [$];
    out_t  none;
    int    qlen;
    logic [31:0] act_set [5];
    logic [31:0] rad_set [5];
    none = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unit normal along x, slab from -10 to 10
    rows.push_back('{mk(OP_LOAD, 0, 16384, 0, 0, -(10 << 16), 10 << 16, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, ov(REL_BACK, 0, 0, 0)});
    rows.push_back('{mk(OP_POINT, 0, 0, 0, 0, 0, 0, 20 << 16, 0, 0, 1), 1,
                     ov(REL_FRONT, 0, 0, 0)});
    // high side inclusive, low side strict
    rows.push_back('{mk(OP_POINT, 0, 0, 0, 0, 0, 0, 10 << 16, 0, 0, 1), 1,
                     ov(REL_BACK, 20 << 16, 0, 0)});
    rows.push_back('{mk(OP_POINT, 0, 0, 0, 0, 0, 0, -(10 << 16), 0, 0, 1), 1,
                     ov(REL_INTER, -(20 << 16), 0, 0)});
    rows.push_back('{mk(OP_POINT, 0, 0, 0, 0, 0, 0, -(5 << 16), 0, 0, 0), 0, none});
    // slab reload in the middle of a query keeps the gathered range
    rows.push_back('{mk(OP_LOAD, 31, -32768, 32767, -32768, 32'sh80000000, 32'sh7fffffff,
                        0, 0, 0, 0), 0, none});
    rows.push_back('{mk(OP_POINT, 0, 0, 0, 0, 0, 0, 5 << 16, 0, 0, 1), 1,
                     ov(REL_BACK, 0, 0, 0)});
    // inverted slab
    rows.push_back('{mk(OP_LOAD, 0, 16384, 0, 0, 5 << 16, -(5 << 16), 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, ov(REL_FRONT, 0, 0, 0)});
    // saturating projections at the field extremes
    rows.push_back('{mk(OP_LOAD, 0, -32768, 32767, -32768, 32'sh80000000, 32'sh7fffffff,
                        0, 0, 0, 0), 0, none});
    rows.push_back('{mk(OP_POINT, 0, 0, 0, 0, 0, 0, 32'sh80000000, 32'sh80000000,
                        32'sh80000000, 1), 0, none});
    rows.push_back('{mk(OP_POINT, 0, 0, 0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000,
                        32'sh7fffffff, 0), 0, none});
    rows.push_back('{mk(OP_POINT, 0, 0, 0, 0, 0, 0, 32'sh80000000, 32'sh7fffffff,
                        32'sh80000000, 1), 0, none});
    rows.push_back('{mk(OP_LOAD, 0, 32767, 32767, 32767, -1, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(OP_POINT, 0, 0, 0, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff,
                        32'sh7fffffff, 1), 0, none});
    rows.push_back('{mk(OP_POINT, 0, 0, 0, 0, 0, 0, -1, -1, -1, 1), 0, none});
    foreach (rows[i]) send_beat(rows[i].b, rows[i].typed, rows[i].want);
    drain_results();

    // register settings per phase, extremes and out-of-range face counts
    act_set = '{32'd1, 32'd0, 32'd32, 32'd63, 32'd7};
    rad_set = '{32'd0, 32'h7fffffff, 32'd0, 32'd3 << 16, 32'd1 << 16};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) begin
        act_set[ph] = $urandom_range(31, 2);
        rad_set[ph] = $urandom_range(2 << 16);
      end
      reg_write(REG_ACTIVE, act_set[ph]);
      reg_write(REG_RADIUS, rad_set[ph]);
      for (int f = 0; f < MAX_FACES; f++) send_beat(face_beat(f, $urandom_range(9) == 0), 0, none);
      repeat (30) begin
        qlen = $urandom_range(4, 1);
        for (int k = 0; k < qlen; k++) begin
          if ($urandom_range(9) == 0)
            send_beat(face_beat($urandom_range(MAX_FACES - 1), $urandom_range(3) == 0), 0, none);
          send_beat(point_beat(k == qlen - 1, $urandom_range(9) < 2), 0, none);
        end
      end
      drain_results();
    end
    sender_busy = 1'b0;
  end

  // end of run
  initial begin
    wait (!sender_busy);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #8ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### convex_slab_hull_overlap_unit.f
sv/csho_pkg.sv
sv/csho_cell.sv
sv/csho_proj.sv
sv/csho_div.sv
sv/convex_slab_hull_overlap_unit.sv
sv/csho_checker.sv
dv/tb_top.sv
